### rtl/core/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

	localparam int BYTE_BITS      = 8;
	localparam int SYM_W          = 8;
	localparam int WIDTH_REG_W    = 4;
	localparam int QUEUE_DEPTH    = 4;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 4'd8;

	// One queue entry: every result word caused by one input symbol.
	// A single-word entry always ends its item; in a two-word entry the
	// second word always ends both item and stream.
	typedef struct packed {
		logic                 two;
		logic [BYTE_BITS-1:0] byte0;
		logic                 slast0;
		logic [BYTE_BITS-1:0] byte1;
	} grp_t;

	// Push request from front to queue.
	typedef struct packed {
		logic push;
		grp_t grp;
	} push_t;

endpackage

### rtl/core/bit_field_packer_top.sv
// ----------------------------------------------------------------------------
// bit_field_packer_top
// MSB-first dense bit packer: symbols of 1..8 bits packed into bytes.
// ----------------------------------------------------------------------------
// Path: a symbol that completes a byte is written into the queue when it is
//   accepted; the output register then loads it from the queue when free.
//   byte_stall can hold it in the queue meanwhile.
// Throughput: one symbol per cycle while the queue has room, one output
//   word per cycle while byte_stall is low; a two-word stream end is split.
// Reset (arst_n low, asynchronous): width back to 8, partial byte and queue
//   cleared, output valid low.
// ----------------------------------------------------------------------------
module bit_field_packer_top #(
	parameter int QUEUE_DEPTH = bfp_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// symbol channel
	input  logic                             sym_valid,
	output logic                             sym_stall,
	input  logic [bfp_pkg::SYM_W-1:0]        symbol,
	input  logic                             stream_end,
	// byte channel
	output logic                             byte_valid,
	input  logic                             byte_stall,
	output logic [bfp_pkg::BYTE_BITS-1:0]    out_byte,
	output logic                             stream_last,
	output logic                             item_last,
	// width register write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bfp_pkg::WIDTH_REG_W-1:0]  cfg_data
);

	bfp_pkg::push_t push;
	bfp_pkg::grp_t  head;
	logic           queue_full;
	logic           queue_empty;
	logic           pop;

	// The width register takes a write on any cycle.
	assign cfg_ready = 1'b1;

	// Front: pack each symbol into the partial byte and emit the words it
	// completes as one group; stall only when the queue has no room.
	bfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.symbol     (symbol),
		.stream_end (stream_end),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push)
	);

	// Queue: decouple symbol intake from output back-pressure.
	bfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.empty  (queue_empty),
		.head   (head)
	);

	// Back: one word per cycle unless stalled; splits two-word groups.
	bfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (queue_empty),
		.head        (head),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.stream_last (stream_last),
		.item_last   (item_last)
	);

endmodule

### rtl/core/bfp_front.sv
// ----------------------------------------------------------------------------
// bfp_front
// Accepts symbols, keeps the partial byte and packs each symbol into it.
// ----------------------------------------------------------------------------
module bfp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sym_valid,
	output logic                             sym_stall,
	input  logic [bfp_pkg::SYM_W-1:0]        symbol,
	input  logic                             stream_end,
	input  logic                             cfg_valid,
	input  logic [bfp_pkg::WIDTH_REG_W-1:0]  cfg_data,
	input  logic                             queue_full,
	output bfp_pkg::push_t                   push
);

	logic [bfp_pkg::WIDTH_REG_W-1:0] width_q;
	logic [7:0]  partial_q;
	logic [2:0]  filled_q;

	logic [3:0]  n_eff;
	logic [7:0]  sym_m;
	logic [4:0]  total;
	logic [4:0]  shamt;
	logic [15:0] acc;
	logic        full;
	logic [4:0]  rem;
	logic        accept;

	// Clamp width to 1..8.
	always_comb begin
		if (width_q == 4'd0) begin
			n_eff = 4'd1;
		end else if (width_q > 4'd8) begin
			n_eff = 4'd8;
		end else begin
			n_eff = width_q;
		end
	end

	always_comb begin
		sym_m = symbol & (8'hFF >> (4'd8 - n_eff));
		total = {2'b00, filled_q} + {1'b0, n_eff};
		shamt = 5'd16 - total;
		acc   = {partial_q, 8'h00} | ({8'h00, sym_m} << shamt);
		full  = (total >= 5'd8);
		rem   = full ? (total - 5'd8) : total;
	end

	assign sym_stall = queue_full;
	assign accept    = sym_valid && !sym_stall;

	always_comb begin
		push.grp.two    = full && stream_end && (rem != 5'd0);
		push.grp.byte0  = acc[15:8];
		push.grp.slast0 = stream_end && (rem == 5'd0 || !full);
		push.grp.byte1  = acc[7:0];
		push.push       = accept && (full || stream_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= bfp_pkg::WIDTH_RESET;
			partial_q <= 8'h00;
			filled_q  <= 3'd0;
		end else begin
			if (cfg_valid) begin
				width_q <= cfg_data;
			end
			if (accept) begin
				if (stream_end) begin
					partial_q <= 8'h00;
					filled_q  <= 3'd0;
				end else begin
					partial_q <= full ? acc[7:0] : acc[15:8];
					filled_q  <= rem[2:0];
				end
			end
		end
	end

endmodule

### rtl/core/bfp_queue.sv
// ----------------------------------------------------------------------------
// bfp_queue
// Small FIFO of result groups between front and back.
// ----------------------------------------------------------------------------
module bfp_queue #(
	parameter int DEPTH = bfp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bfp_pkg::push_t push,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output bfp_pkg::grp_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bfp_pkg::grp_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/bfp_back.sv
// ----------------------------------------------------------------------------
// bfp_back
// Splits queued groups into single words and drives the output register.
// ----------------------------------------------------------------------------
module bfp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  bfp_pkg::grp_t                head,
	output logic                         pop,
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [bfp_pkg::BYTE_BITS-1:0] out_byte,
	output logic                         stream_last,
	output logic                         item_last
);

	logic half_q;
	logic valid_q;
	logic load;
	logic first_of_two;

	assign load         = (!valid_q || !byte_stall) && !empty;
	assign first_of_two = head.two && !half_q;
	assign pop          = load && !first_of_two;
	assign byte_valid   = valid_q;

	// Payload: no reset needed.
	always_ff @(posedge clk) begin
		if (load) begin
			if (half_q) begin
				out_byte    <= head.byte1;
				stream_last <= 1'b1;
				item_last   <= 1'b1;
			end else begin
				out_byte    <= head.byte0;
				stream_last <= head.slast0;
				item_last   <= !head.two;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q  <= first_of_two;
			end else if (!byte_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/bfp_checker.sv
// ----------------------------------------------------------------------------
// bfp_checker
// Port-level checks on the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module bfp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             sym_valid,
	input logic                             sym_stall,
	input logic [bfp_pkg::SYM_W-1:0]        symbol,
	input logic                             stream_end,
	input logic                             byte_valid,
	input logic                             byte_stall,
	input logic [bfp_pkg::BYTE_BITS-1:0]    out_byte,
	input logic                             stream_last,
	input logic                             item_last,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [bfp_pkg::WIDTH_REG_W-1:0]  cfg_data
);

	// Hold a stalled word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(out_byte)
			&& $stable(stream_last) && $stable(item_last))
		else $error("stalled output word changed");

	// The final word of a stream always ends its symbol.
	a_slast: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && stream_last |-> item_last)
		else $error("stream_last without item_last");

	// The second word of a symbol follows without a gap.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !item_last |=> byte_valid)
		else $error("gap inside a symbol's words");

	// A partial word of a symbol never closes a stream, so the next one does.
	a_pair_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !item_last && !byte_stall |=> stream_last && item_last)
		else $error("second word of a pair does not close the stream");

endmodule

bind bit_field_packer_top bfp_checker u_bfp_checker (.*);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSB-first bit packer. A short table of
// hand-picked symbols comes first, covering saturated widths, straddled
// bytes, flushes and double-word stream ends. Random streams at changing
// widths and idle patterns follow. Every byte word is checked against the
// table's own words or an in-bench packing predictor.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1725;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_EDGES = 4;

	// Idle patterns applied to the two channels, one per random segment.
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// One byte word as the block should present it.
	typedef struct packed {
		logic [bfp_pkg::BYTE_BITS-1:0] data;
		logic                          slast;
		logic                          ilast;
	} pack_word_t;

	// One row of the directed table. n < 0 means "ask the predictor".
	typedef struct {
		bit                              wr;
		logic [bfp_pkg::WIDTH_REG_W-1:0] width;
		logic [bfp_pkg::SYM_W-1:0]       sym;
		logic                            fin;
		int                              n;
		pack_word_t                      e0;
		pack_word_t                      e1;
	} plan_row_t;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            sym_valid  = 1'b0;
	logic                            sym_stall;
	logic [bfp_pkg::SYM_W-1:0]       symbol     = '0;
	logic                            stream_end = 1'b0;
	logic                            byte_valid;
	logic                            byte_stall = 1'b0;
	logic [bfp_pkg::BYTE_BITS-1:0]   out_byte;
	logic                            stream_last;
	logic                            item_last;
	logic                            cfg_valid  = 1'b0;
	logic                            cfg_ready;
	logic [bfp_pkg::WIDTH_REG_W-1:0] cfg_data   = '0;

	// Predictor state: the width register and the pending partial byte.
	logic [bfp_pkg::WIDTH_REG_W-1:0] width_reg = bfp_pkg::WIDTH_RESET;
	logic [bfp_pkg::BYTE_BITS-1:0]   held_byte = '0;
	int                              held_fill = 0;

	pack_word_t expected_words[$];
	plan_row_t  plan[$];
	idle_mode_t idle_mode = IDLE_NONE;

	int n_errors    = 0;
	int n_symbols   = 0;
	int n_directed  = 0;
	int n_checked   = 0;
	int n_writes    = 0;
	int idle_cycles = 0;

	bit_field_packer_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.symbol      (symbol),
		.stream_end  (stream_end),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.stream_last (stream_last),
		.item_last   (item_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// 20 ns clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Pack one accepted symbol into the predictor's partial byte. Return how
	// many words it completes (0..2) in w0 and w1, and advance the state.
	function automatic int pack_symbol(input logic [bfp_pkg::SYM_W-1:0] sym,
			input logic fin, output pack_word_t w0, output pack_word_t w1);
		int          n;
		int          total;
		int          cnt;
		logic [15:0] masked;
		logic [15:0] window;
		pack_word_t  tail;
		// A width of 0 acts as 1, anything above 8 acts as 8.
		if (width_reg == 0)
			n = 1;
		else if (width_reg > bfp_pkg::BYTE_BITS)
			n = bfp_pkg::BYTE_BITS;
		else
			n = int'(width_reg);
		masked = 16'(sym) & ((16'h1 << n) - 16'h1);
		total  = held_fill + n;
		// Keep the pending bits MSB-aligned in a 16-bit window, new bits after.
		window = {held_byte, 8'h00} | (masked << (16 - total));
		cnt    = 0;
		w0     = '0;
		w1     = '0;
		if (total >= bfp_pkg::BYTE_BITS) begin
			total -= bfp_pkg::BYTE_BITS;
			w0.data  = window[15:8];
			w0.slast = fin && (total == 0);
			w0.ilast = !fin || (total == 0);
			cnt      = 1;
			window   = window << bfp_pkg::BYTE_BITS;
		end
		if (fin) begin
			// Flush any remainder, zero padded, as the stream's final word.
			if (total > 0) begin
				tail.data  = window[15:8];
				tail.slast = 1'b1;
				tail.ilast = 1'b1;
				if (cnt == 0)
					w0 = tail;
				else
					w1 = tail;
				cnt++;
			end
			held_byte = '0;
			held_fill = 0;
		end else begin
			held_byte = window[15:8];
			held_fill = total;
		end
		return cnt;
	endfunction

	function automatic int send_gap_pct();
		case (idle_mode)
			IDLE_SEND: return 50;
			IDLE_BOTH: return 35;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (idle_mode)
			IDLE_RECV: return 50;
			IDLE_BOTH: return 35;
			default:   return 0;
		endcase
	endfunction

	task automatic add_row(input bit wr, input logic [bfp_pkg::WIDTH_REG_W-1:0] wd,
			input logic [bfp_pkg::SYM_W-1:0] sym, input logic fin, input int n,
			input logic [7:0] b0, input logic s0, input logic i0,
			input logic [7:0] b1, input logic s1, input logic i1);
		plan_row_t r;
		r.wr    = wr;
		r.width = wd;
		r.sym   = sym;
		r.fin   = fin;
		r.n     = n;
		r.e0    = '{b0, s0, i0};
		r.e1    = '{b1, s1, i1};
		plan.push_back(r);
	endtask

	// Offer one symbol word, hold it until accepted, then queue what it
	// should produce: the typed words when typed_n >= 0, else the predictor's.
	task automatic send_symbol(input logic [bfp_pkg::SYM_W-1:0] sym, input logic fin,
			input int typed_n, input pack_word_t t0, input pack_word_t t1);
		pack_word_t p0;
		pack_word_t p1;
		int         pn;
		while ($urandom_range(99) < send_gap_pct()) begin
			sym_valid <= 1'b0;
			@(posedge clk);
		end
		sym_valid  <= 1'b1;
		symbol     <= sym;
		stream_end <= fin;
		do @(posedge clk); while (sym_stall);
		// The predictor always runs so its state tracks the block.
		pn = pack_symbol(sym, fin, p0, p1);
		if (typed_n >= 0) begin
			pn = typed_n;
			p0 = t0;
			p1 = t1;
		end
		if (pn >= 1)
			expected_words.push_back(p0);
		if (pn == 2)
			expected_words.push_back(p1);
		n_symbols++;
	endtask

	// Drop valid, wait for every expected word, then let the pipeline empty
	// of symbols that produced nothing yet.
	task automatic settle();
		sym_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_EDGES) @(posedge clk);
	endtask

	task automatic write_width(input logic [bfp_pkg::WIDTH_REG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		width_reg = v;
		n_writes++;
	endtask

	// Receiver: stall at the rate of the current idle pattern.
	always @(posedge clk) begin
		byte_stall <= ($urandom_range(99) < recv_stall_pct());
	end

	// Checker: compare each accepted byte word with the oldest expectation.
	always @(posedge clk) begin
		pack_word_t want;
		if (arst_n && byte_valid && !byte_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected byte word %02h (stream_last %0b, item_last %0b)",
					out_byte, stream_last, item_last);
				n_errors++;
			end else begin
				want = expected_words.pop_front();
				n_checked++;
				if (out_byte !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, out_byte);
					n_errors++;
				end
				if (stream_last !== want.slast) begin
					$error("stream_last: expected %0b, got %0b", want.slast, stream_last);
					n_errors++;
				end
				if (item_last !== want.ilast) begin
					$error("item_last: expected %0b, got %0b", want.ilast, item_last);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: end the run if no channel moves a word for too long.
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((sym_valid && !sym_stall) || (byte_valid && !byte_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no handshake for %0d cycles, %0d words still expected",
			STALL_LIMIT, expected_words.size());
		$display("tb_top: done, errors");
		$finish;
	end

	// Stimulus.
	initial begin
		int         n_random;
		int         seg;
		int         seg_end;
		int         len;
		logic [3:0] wv;

		// Directed table. After reset the width is 8.
		add_row(0, 4'd0,  8'hFF, 1'b0,  1, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
		// Final symbol exactly completes a byte: single word, stream_last set.
		add_row(0, 4'd0,  8'h00, 1'b1,  1, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'hA5, 1'b1,  1, 8'hA5, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		// Width 0 acts as 1 bit; first symbol gives nothing, then a flush.
		add_row(1, 4'd0,  8'hFF, 1'b0,  0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'hFE, 1'b1,  1, 8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		// Width 15 saturates to 8.
		add_row(1, 4'd15, 8'h3C, 1'b0,  1, 8'h3C, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
		// Width 4: two nibbles make a byte, then a half-byte flush.
		add_row(1, 4'd4,  8'hFA, 1'b0,  0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h05, 1'b0,  1, 8'hA5, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h0F, 1'b1,  1, 8'hF0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		// Width 3: upper bits ignored, then a stream end that both completes a
		// byte and leaves one bit over - two words, only the second ends it.
		add_row(1, 4'd3,  8'h07, 1'b0,  0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'hF8, 1'b0,  0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h07, 1'b1,  2, 8'hE3, 1'b0, 1'b0, 8'h80, 1'b1, 1'b1);
		// Width 7: symbol straddles two bytes on a stream end.
		add_row(1, 4'd7,  8'h7F, 1'b0,  0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h81, 1'b1,  2, 8'hFE, 1'b0, 1'b0, 8'h04, 1'b1, 1'b1);
		add_row(1, 4'd1,  8'h01, 1'b1,  1, 8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(1, 4'd9,  8'h5A, 1'b1,  1, 8'h5A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
		// Remaining rows go to the predictor.
		add_row(1, 4'd5,  8'hFF, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h13, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'hE0, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h0A, 1'b1, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(1, 4'd6,  8'h2A, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h15, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h3F, 1'b1, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(1, 4'd2,  8'h03, 1'b0, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(0, 4'd0,  8'h02, 1'b1, -1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);

		// Hold reset low, then release it once.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with no idling.
		foreach (plan[i]) begin
			if (plan[i].wr) begin
				settle();
				write_width(plan[i].width);
			end
			send_symbol(plan[i].sym, plan[i].fin, plan[i].n, plan[i].e0, plan[i].e1);
		end
		n_directed = n_symbols;

		// Random segments: a new width and idle pattern each time, mostly whole
		// streams of random length, some loose symbols with a random end flag.
		n_random = 0;
		seg      = 0;
		while (n_random < RANDOM_ITEMS) begin
			settle();
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0:       wv = 4'd0;
					1:       wv = 4'd1;
					2:       wv = 4'd8;
					default: wv = 4'd15;
				endcase
			end else begin
				wv = 4'($urandom_range(15));
			end
			write_width(wv);
			idle_mode = idle_mode_t'(seg % 4);
			seg_end   = n_random + $urandom_range(60, 140);
			if (seg_end > RANDOM_ITEMS)
				seg_end = RANDOM_ITEMS;
			while (n_random < seg_end) begin
				if ($urandom_range(99) < 85) begin
					len = $urandom_range(1, 24);
					if (len > seg_end - n_random)
						len = seg_end - n_random;
					for (int k = 0; k < len; k++) begin
						send_symbol(8'($urandom_range(255)), k == len - 1, -1, '0, '0);
						n_random++;
					end
				end else begin
					send_symbol(8'($urandom_range(255)), 1'($urandom_range(1)),
						-1, '0, '0);
					n_random++;
				end
			end
			seg++;
		end

		// Drain: stop stalling, wait for the last words, then watch for strays.
		sym_valid <= 1'b0;
		idle_mode = IDLE_NONE;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			n_errors++;
		end
		$display("tb_top: %0d symbols (%0d from the table), %0d byte words checked,",
			n_symbols, n_directed, n_checked);
		$display("tb_top: %0d width writes over %0d random segments, four idle patterns",
			n_writes, seg);
		if (n_errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
